// ===== design/mchw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mchw_pkg;

	localparam int CHANNELS  = 8;
	localparam int TIME_BITS = 32;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int APB_AW = 5;

	localparam logic [31:0] STALL_LIMIT_RST   = 32'd5000;
	localparam logic [31:0] RELAXED_LIMIT_RST = 32'd10000;
	localparam logic [29:0] PERIOD_RST        = 30'd500;
	localparam logic [31:0] REDUMP_RST        = 32'd10000;
	localparam logic [7:0]  RELAXED_MASK_RST  = 8'd96;

	typedef enum logic [1:0] {
		CMD_BEAT   = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_BEGIN  = 2'd2,
		CMD_END    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_STALL_LIMIT   = 3'd0,
		REG_RELAXED_LIMIT = 3'd1,
		REG_SAMPLE_PERIOD = 3'd2,
		REG_REDUMP        = 3'd3,
		REG_RELAXED_MASK  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [2:0]  channel;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [7:0] stalled_mask;
		logic       report;
		logic       first_of_episode;
		logic [2:0] root_channel;
		logic [3:0] stalled_count;
		logic       unbalanced_end;
		logic       expected_active;
	} out_item_t;

endpackage

`default_nettype wire

// ===== design/mchw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mchw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/multi_channel_heartbeat_watchdog.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Heartbeat watchdog over CHANNELS channels. Beat, begin and end items update
// flags and the expected-stall counter in the accept cycle and go straight to
// the finish step, which loads the result. A sample item goes through setup,
// then walks the channels one per cycle through the last-beat-time memory (one
// read or write per channel), then the read pipeline drain, the report decision
// and the output load. A stalled output holds the finish step before the load.
// The output register holds a finished result while the next item is taken.
// Registers sit at byte addresses 0, 4, 8, 12 and 16 of the APB port and read
// back as written, but for the low 30 bits of the period and 8 of the mask.
module multi_channel_heartbeat_watchdog
	import mchw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire in_item_t          in_item,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output out_item_t              out_item
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PREP   = 6'b000010,
		ST_WALK   = 6'b000100,
		ST_DRAIN  = 6'b001000,
		ST_DECIDE = 6'b010000,
		ST_FIN    = 6'b100000
	} state_t;

	state_t state_q;

	logic [31:0] stall_limit_q;
	logic [31:0] relaxed_limit_q;
	logic [29:0] period_q;
	logic [31:0] redump_q;
	logic [7:0]  relaxed_mask_q;

	logic [CHANNELS-1:0] started_q;
	logic [CHANNELS-1:0] pending_q;
	logic [CHANNELS-1:0] flags_q;
	logic [CHANNELS-1:0] acc_flags_q;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] last_sample_q;
	logic [TIME_BITS-1:0] last_report_q;
	logic was_stalled_q;
	logic was_expected_q;
	logic [7:0] depth_q;
	logic rebase_q;

	logic [IDX_W-1:0] idx_q;
	logic chk_s1;
	logic [IDX_W-1:0] idx_s1;
	logic chk_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [TIME_BITS-1:0] age_s2;
	logic [TIME_BITS-1:0] best_age_q;
	logic [IDX_W-1:0] best_idx_q;
	logic best_found_q;

	logic report_q;
	logic first_q;
	logic [IDX_W-1:0] root_q;
	logic unbal_q;

	logic out_valid_q;
	out_item_t out_q;

	logic in_accept;
	logic cfg_write;
	logic [2:0] reg_idx;
	logic [IDX_W-1:0] beat_idx;
	logic [CHANNELS-1:0] relaxed_vec;
	logic walk_start;
	logic walk_fresh;
	logic ram_we;
	logic [TIME_BITS-1:0] ram_rdata;
	logic [TIME_BITS-1:0] age_s1;
	logic [31:0] limit_s2;
	logic over_s2;
	logic better_s2;
	logic suspended;
	logic redump_hold;
	logic [CNT_W-1:0] flag_count;
	logic out_free;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign reg_idx   = paddr[4:2];
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign beat_idx  = IDX_W'(in_item.channel);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		unique case (reg_idx)
			REG_STALL_LIMIT:   prdata = stall_limit_q;
			REG_RELAXED_LIMIT: prdata = relaxed_limit_q;
			REG_SAMPLE_PERIOD: prdata = {2'b00, period_q};
			REG_REDUMP:        prdata = redump_q;
			REG_RELAXED_MASK:  prdata = {24'd0, relaxed_mask_q};
			default:           prdata = 32'd0;
		endcase
	end

	// channels past the mask width use the normal limit
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			relaxed_vec[i] = (i < 8) ? relaxed_mask_q[i % 8] : 1'b0;
		end
	end

	always_comb begin
		flag_count = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			flag_count = flag_count + CNT_W'(flags_q[i]);
		end
	end

	assign walk_start = started_q[idx_q] || pending_q[idx_q];
	assign walk_fresh = pending_q[idx_q] || rebase_q;
	assign ram_we     = (state_q == ST_WALK) && walk_start && walk_fresh;

	mchw_ram #(
		.WIDTH (TIME_BITS),
		.DEPTH (CHANNELS)
	) u_beat_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (now_q),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign age_s1      = now_q - ram_rdata;
	assign limit_s2    = relaxed_vec[idx_s2] ? relaxed_limit_q : stall_limit_q;
	assign over_s2     = CMP_W'(age_s2) > CMP_W'(limit_s2);
	assign better_s2   = !best_found_q || (age_s2 > best_age_q);
	assign suspended   = CMP_W'(now_q - last_sample_q) > CMP_W'({period_q, 2'b00});
	assign redump_hold = was_stalled_q &&
		(CMP_W'(now_q - last_report_q) < CMP_W'(redump_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			stall_limit_q   <= STALL_LIMIT_RST;
			relaxed_limit_q <= RELAXED_LIMIT_RST;
			period_q        <= PERIOD_RST;
			redump_q        <= REDUMP_RST;
			relaxed_mask_q  <= RELAXED_MASK_RST;
			started_q       <= '0;
			pending_q       <= '0;
			flags_q         <= '0;
			acc_flags_q     <= '0;
			now_q           <= '0;
			last_sample_q   <= '0;
			last_report_q   <= '0;
			was_stalled_q   <= 1'b0;
			was_expected_q  <= 1'b0;
			depth_q         <= '0;
			rebase_q        <= 1'b0;
			idx_q           <= '0;
			chk_s1          <= 1'b0;
			idx_s1          <= '0;
			chk_s2          <= 1'b0;
			idx_s2          <= '0;
			age_s2          <= '0;
			best_age_q      <= '0;
			best_idx_q      <= '0;
			best_found_q    <= 1'b0;
			report_q        <= 1'b0;
			first_q         <= 1'b0;
			root_q          <= '0;
			unbal_q         <= 1'b0;
			out_valid_q     <= 1'b0;
			out_q           <= '0;
		end else begin
			if (cfg_write) begin
				unique case (reg_idx)
					REG_STALL_LIMIT:   stall_limit_q   <= pwdata;
					REG_RELAXED_LIMIT: relaxed_limit_q <= pwdata;
					REG_SAMPLE_PERIOD: period_q        <= pwdata[29:0];
					REG_REDUMP:        redump_q        <= pwdata;
					REG_RELAXED_MASK:  relaxed_mask_q  <= pwdata[7:0];
					default: ;
				endcase
			end

			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// read pipeline: s1 carries the memory read, s2 the age
			chk_s1 <= (state_q == ST_WALK) && walk_start && !walk_fresh;
			idx_s1 <= idx_q;
			chk_s2 <= chk_s1;
			idx_s2 <= idx_s1;
			age_s2 <= age_s1;
			if (chk_s2 && over_s2) begin
				acc_flags_q[idx_s2] <= 1'b1;
				if (better_s2) begin
					best_found_q <= 1'b1;
					best_age_q   <= age_s2;
					best_idx_q   <= idx_s2;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						report_q <= 1'b0;
						first_q  <= 1'b0;
						root_q   <= '0;
						unbal_q  <= 1'b0;
						now_q    <= TIME_BITS'(in_item.now_ms);
						state_q  <= (in_item.cmd == CMD_SAMPLE) ? ST_PREP : ST_FIN;
						unique case (in_item.cmd)
							CMD_BEAT: begin
								if (int'(in_item.channel) < CHANNELS) begin
									pending_q[beat_idx] <= 1'b1;
								end
							end
							CMD_SAMPLE: ;
							CMD_BEGIN: begin
								if (depth_q != 8'hFF) begin
									depth_q <= depth_q + 8'd1;
								end
							end
							default: begin
								if (depth_q == 8'd0) begin
									unbal_q <= 1'b1;
								end else begin
									depth_q <= depth_q - 8'd1;
								end
							end
						endcase
					end
				end
				ST_PREP: begin
					rebase_q       <= suspended || (depth_q != 8'd0) || was_expected_q;
					was_expected_q <= (depth_q != 8'd0);
					last_sample_q  <= now_q;
					idx_q          <= '0;
					acc_flags_q    <= '0;
					best_found_q   <= 1'b0;
					best_age_q     <= '0;
					best_idx_q     <= '0;
					state_q        <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_start) begin
						started_q[idx_q] <= 1'b1;
						if (walk_fresh) begin
							pending_q[idx_q] <= 1'b0;
						end
					end
					if (idx_q == IDX_W'(CHANNELS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!chk_s1 && !chk_s2) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					flags_q <= acc_flags_q;
					if (acc_flags_q == '0) begin
						was_stalled_q <= 1'b0;
					end else if (!redump_hold) begin
						report_q      <= 1'b1;
						first_q       <= !was_stalled_q;
						root_q        <= best_idx_q;
						was_stalled_q <= 1'b1;
						last_report_q <= now_q;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_q.stalled_mask     <= 8'(flags_q);
						out_q.report           <= report_q;
						out_q.first_of_episode <= first_q;
						out_q.root_channel     <= 3'(root_q);
						out_q.stalled_count    <= 4'(flag_count);
						out_q.unbalanced_end   <= unbal_q;
						out_q.expected_active  <= (depth_q != 8'd0);
						state_q                <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result is only loaded from the finish step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside finish step");

	// the age stage only runs while a sample walks the channels or drains the reads
	assert property (@(posedge clk) disable iff (!arst_n)
		chk_s2 |-> (state_q == ST_WALK || state_q == ST_DRAIN))
		else $error("age check outside channel walk");

	// a report always names a stalled channel
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.report) |->
			(out_q.stalled_mask[out_q.root_channel] && out_q.stalled_count != 4'd0))
		else $error("report without matching stalled channel");

	// count and mask of a result agree
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (32'(out_q.stalled_count) == $countones(out_q.stalled_mask)))
		else $error("stalled count disagrees with mask");

endmodule

`default_nettype wire
